### rtl/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg: shared types and constants for the postfix expression evaluator
// Character codes, result status codes, ALU opcodes and state encodings.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned CH_W            = 8;
  localparam int unsigned STAT_W          = 3;
  localparam int unsigned CNT_W           = $clog2(DATA_W);

  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [CH_W-1:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;  // '*'
  localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;  // '/'
  localparam logic [CH_W-1:0] CH_PCT   = 8'h25;  // '%'

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_OVERFLOW  = 3'd1,
    STAT_UNDERFLOW = 3'd2,
    STAT_INVALID   = 3'd3,
    STAT_DIVZERO   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_REM
  } alu_op_e;

  typedef enum logic [2:0] {
    AL_IDLE,
    AL_ADD,
    AL_MUL,
    AL_NEGA,
    AL_NEGB,
    AL_DIV,
    AL_FIX
  } alu_state_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RDTOP,
    S_RDB,
    S_RDA,
    S_ALU,
    S_EMIT
  } seq_state_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

endpackage

### rtl/postfix_expression_evaluator_core.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_core: postfix evaluator on a bounded stack
// One character per request; not ready while a request is in work.
// Multiply and divide/remainder run the 32-step shift-add / restoring loop of the
// shared ALU. A result is emitted after a stack or character error, an end
// marker or a zero divisor, and waits while an earlier result is held.
// Async active-low reset empties the stack and drops any pending result.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_core import pfe_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [CH_W-1:0]   s_axis_tdata,   // [7:0] ch
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] value
  output logic [STAT_W-1:0] m_axis_tuser    // [2:0] status
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

  seq_state_e        state_q, state_d;
  logic [DW-1:0]     depth_q, depth_d;
  logic [CH_W-1:0]   ch_q, ch_d;
  logic [DATA_W-1:0] b_q, b_d;
  logic [DATA_W-1:0] emit_val_q, emit_val_d;
  status_e           emit_st_q, emit_st_d;
  logic              m_valid_q;
  logic [DATA_W-1:0] m_data_q;
  logic [STAT_W-1:0] m_user_q;

  logic [DW-1:0]     depth_m1, depth_m2;
  logic              is_digit, is_op, out_load;
  alu_op_e           alu_op;
  alu_req_t          alu_req;
  logic              alu_done;
  logic [DATA_W-1:0] alu_result;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;

  assign depth_m1 = depth_q - DW'(1);
  assign depth_m2 = depth_q - DW'(2);
  assign is_digit = (ch_q >= CH_ZERO) && (ch_q <= CH_NINE);

  always_comb begin
    is_op  = 1'b1;
    alu_op = OP_ADD;
    case (ch_q)
      CH_PLUS:  alu_op = OP_ADD;
      CH_MINUS: alu_op = OP_SUB;
      CH_STAR:  alu_op = OP_MUL;
      CH_SLASH: alu_op = OP_DIV;
      CH_PCT:   alu_op = OP_REM;
      default:  is_op  = 1'b0;
    endcase
  end

  always_comb begin
    state_d       = state_q;
    depth_d       = depth_q;
    ch_d          = ch_q;
    b_d           = b_q;
    emit_val_d    = emit_val_q;
    emit_st_d     = emit_st_q;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = depth_q[AW-1:0];
    mem_wdata     = DATA_W'(ch_q - CH_ZERO);
    mem_re        = 1'b0;
    mem_raddr     = depth_m1[AW-1:0];
    alu_req.start = 1'b0;
    alu_req.op    = alu_op;
    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          ch_d    = s_axis_tdata;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        // every error path clears the stack and reports a zero value
        emit_val_d = '0;
        if (is_digit) begin
          if (depth_q == DW'(STACK_DEPTH)) begin
            emit_st_d = STAT_OVERFLOW;
            depth_d   = '0;
            state_d   = S_EMIT;
          end else begin
            mem_we  = 1'b1;
            depth_d = depth_q + DW'(1);
            state_d = S_IDLE;
          end
        end else if (ch_q == CH_HASH) begin
          if (depth_q == '0) begin
            emit_st_d = STAT_UNDERFLOW;
            depth_d   = '0;
            state_d   = S_EMIT;
          end else begin
            mem_re  = 1'b1;
            state_d = S_RDTOP;
          end
        end else if (depth_q < DW'(2)) begin
          emit_st_d = STAT_UNDERFLOW;
          depth_d   = '0;
          state_d   = S_EMIT;
        end else if (!is_op) begin
          emit_st_d = STAT_INVALID;
          depth_d   = '0;
          state_d   = S_EMIT;
        end else begin
          mem_re  = 1'b1;
          state_d = S_RDB;
        end
      end
      S_RDTOP: begin
        emit_val_d = mem_rdata;
        emit_st_d  = STAT_OK;
        depth_d    = '0;
        state_d    = S_EMIT;
      end
      S_RDB: begin
        b_d       = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = depth_m2[AW-1:0];
        state_d   = S_RDA;
      end
      S_RDA: begin
        if ((alu_op == OP_DIV || alu_op == OP_REM) && b_q == '0) begin
          emit_val_d = '0;
          emit_st_d  = STAT_DIVZERO;
          depth_d    = '0;
          state_d    = S_EMIT;
        end else begin
          alu_req.start = 1'b1;
          state_d       = S_ALU;
        end
      end
      S_ALU: begin
        if (alu_done) begin
          mem_we    = 1'b1;
          mem_waddr = depth_m2[AW-1:0];
          mem_wdata = alu_result;
          depth_d   = depth_m1;
          state_d   = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      depth_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q       <= ch_d;
    b_q        <= b_d;
    emit_val_q <= emit_val_d;
    emit_st_q  <= emit_st_d;
    if (out_load) begin
      m_data_q <= emit_val_q;
      m_user_q <= emit_st_q;
    end
  end

  pfe_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  pfe_alu u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (alu_req),
    .a_i     (mem_rdata),
    .b_i     (b_q),
    .done_o  (alu_done),
    .result_o(alu_result)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

### rtl/pfe_stack.sv
// ----------------------------------------------------------------------------
// pfe_stack: operand store
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module pfe_stack import pfe_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  localparam int unsigned AW = $clog2(STACK_DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/pfe_alu.sv
// ----------------------------------------------------------------------------
// pfe_alu: iterative arithmetic unit
// One 33-bit adder/subtractor shared by add, sub, shift-add multiply and
// restoring divide/remainder on magnitudes with a final sign fix.
// ----------------------------------------------------------------------------
module pfe_alu import pfe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  alu_req_t          req_i,
  input  logic [DATA_W-1:0] a_i,
  input  logic [DATA_W-1:0] b_i,
  output logic              done_o,
  output logic [DATA_W-1:0] result_o
);

  alu_state_e        state_q, state_d;
  alu_op_e           op_q, op_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic [DATA_W-1:0] mq_q, mq_d;
  logic [DATA_W-1:0] dv_q, dv_d;
  logic [DATA_W-1:0] res_q, res_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              sa_q, sa_d, sb_q, sb_d;
  logic              done_q, done_d;

  logic [DATA_W-1:0] add_x, add_y, fix_val;
  logic              add_sub, fix_neg, last_iter;
  logic [DATA_W:0]   sum;

  // shared adder; for subtraction sum[DATA_W] is the borrow
  assign sum = {1'b0, add_x} + ({1'b0, add_y} ^ {(DATA_W+1){add_sub}})
             + (DATA_W+1)'(add_sub);

  assign last_iter = (cnt_q == CNT_W'(DATA_W - 1));

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    acc_d   = acc_q;
    mq_d    = mq_q;
    dv_d    = dv_q;
    res_d   = res_q;
    cnt_d   = cnt_q;
    sa_d    = sa_q;
    sb_d    = sb_q;
    done_d  = 1'b0;
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    fix_val = (op_q == OP_DIV) ? mq_q : acc_q;
    fix_neg = (op_q == OP_DIV) ? (sa_q ^ sb_q) : sa_q;
    case (state_q)
      AL_IDLE: begin
        if (req_i.start) begin
          op_d  = req_i.op;
          sa_d  = a_i[DATA_W-1];
          sb_d  = b_i[DATA_W-1];
          cnt_d = '0;
          case (req_i.op)
            OP_MUL: begin
              acc_d   = '0;
              dv_d    = a_i;
              mq_d    = b_i;
              state_d = AL_MUL;
            end
            OP_DIV, OP_REM: begin
              acc_d   = a_i;
              dv_d    = b_i;
              state_d = AL_NEGA;
            end
            default: begin
              acc_d   = a_i;
              dv_d    = b_i;
              state_d = AL_ADD;
            end
          endcase
        end
      end
      AL_ADD: begin
        add_x   = acc_q;
        add_y   = dv_q;
        add_sub = (op_q == OP_SUB);
        res_d   = sum[DATA_W-1:0];
        done_d  = 1'b1;
        state_d = AL_IDLE;
      end
      AL_MUL: begin
        add_x = acc_q;
        add_y = dv_q;
        if (mq_q[0]) begin
          acc_d = sum[DATA_W-1:0];
        end
        dv_d  = {dv_q[DATA_W-2:0], 1'b0};
        mq_d  = {1'b0, mq_q[DATA_W-1:1]};
        cnt_d = cnt_q + CNT_W'(1);
        if (last_iter) begin
          res_d   = mq_q[0] ? sum[DATA_W-1:0] : acc_q;
          done_d  = 1'b1;
          state_d = AL_IDLE;
        end
      end
      AL_NEGA: begin
        add_y   = acc_q;
        add_sub = 1'b1;
        mq_d    = sa_q ? sum[DATA_W-1:0] : acc_q;
        acc_d   = '0;
        state_d = AL_NEGB;
      end
      AL_NEGB: begin
        add_y   = dv_q;
        add_sub = 1'b1;
        dv_d    = sb_q ? sum[DATA_W-1:0] : dv_q;
        state_d = AL_DIV;
      end
      AL_DIV: begin
        // partial remainder stays below the divisor, so the top bit is free
        add_x   = {acc_q[DATA_W-2:0], mq_q[DATA_W-1]};
        add_y   = dv_q;
        add_sub = 1'b1;
        acc_d   = sum[DATA_W] ? add_x : sum[DATA_W-1:0];
        mq_d    = {mq_q[DATA_W-2:0], ~sum[DATA_W]};
        cnt_d   = cnt_q + CNT_W'(1);
        if (last_iter) begin
          state_d = AL_FIX;
        end
      end
      AL_FIX: begin
        add_y   = fix_val;
        add_sub = 1'b1;
        res_d   = fix_neg ? sum[DATA_W-1:0] : fix_val;
        done_d  = 1'b1;
        state_d = AL_IDLE;
      end
      default: begin
        state_d = AL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AL_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    acc_q <= acc_d;
    mq_q  <= mq_d;
    dv_q  <= dv_d;
    res_q <= res_d;
    cnt_q <= cnt_d;
    sa_q  <= sa_d;
    sb_q  <= sb_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

### rtl/pfe_checker.sv
// ----------------------------------------------------------------------------
// pfe_checker: port-level checks for the postfix evaluator
// Watches the stream ports of the core; attached by bind.
// ----------------------------------------------------------------------------
module pfe_checker import pfe_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [DATA_W-1:0] m_axis_tdata,
  input logic [STAT_W-1:0] m_axis_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= STAT_W'(STAT_DIVZERO))
    else $error("status code out of range");

  // errors carry a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != STAT_W'(STAT_OK) |-> m_axis_tdata == '0)
    else $error("error result with nonzero value");

  // one request at a time: ready drops after a request is taken
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready stayed high after a request");

endmodule

bind postfix_expression_evaluator_core pfe_checker u_pfe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
